### rtl/lag64_mwc_pkg.sv
// ----------------------------------------------------------------------------
// lag64_mwc_pkg
// constants shared by the lag-64 multiply-with-carry generator
// ----------------------------------------------------------------------------
package lag64_mwc_pkg;

    // generator geometry
    localparam int LAG   = 64;
    localparam int IDX_W = (LAG > 1) ? $clog2(LAG) : 1;

    // field widths
    localparam int WORD_W = 64;
    localparam int HALF_W = 32;

    // multiply-with-carry multiplier and carry after seeding
    localparam logic [63:0] MWC_MULT   = 64'hf6a64c36f2d94699;
    localparam logic [63:0] CARRY_INIT = 64'd1234567890;

    // seed mixer constants
    localparam logic [63:0] MIX_OR   = 64'h0000000040000005;
    localparam logic [63:0] MIX_MULT = 64'd6906969069;
    localparam int          ROT_A    = 17;
    localparam int          ROT_B    = 53;

    // item kinds carried on tuser
    localparam logic KIND_PRODUCE = 1'b0;
    localparam logic KIND_SEED    = 1'b1;

endpackage

### rtl/lag64_multiply_with_carry_prng.sv
// ----------------------------------------------------------------------------
// lag64_multiply_with_carry_prng
// lag-64 multiply-with-carry generator, base 2^64, with seeding and warmup
// ----------------------------------------------------------------------------
// produce word: the next word is accepted only once the previous one is written back
// and placed in the output register; one shared 32x32 multiplier does four partial products
// seed word: a 64-word fill from the seed mixer, then 64 passes of 64 updates,
// during which s_tready is low; it returns no word
// reset (aresetn low, synchronous): words read as zero, carry 1234567890,
// position 0, output channel empty
module lag64_multiply_with_carry_prng (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] seed_lo, [127:64] seed_hi
    input  logic [0:0]   s_tuser,   // [0] kind

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // [63:0] random_word
);

    localparam int W  = lag64_mwc_pkg::WORD_W;
    localparam int H  = lag64_mwc_pkg::HALF_W;
    localparam int IW = lag64_mwc_pkg::IDX_W;

    localparam logic [IW-1:0] LAST_IDX = IW'(lag64_mwc_pkg::LAG - 1);

    // control sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_READ,   // produce: read data back, prime the multiply
        ST_P_WB,     // produce: write word and carry, present result
        ST_P_OUT,    // produce: wait for output register to free up
        ST_M_SQR,    // seed: start s*s for current mixer stream
        ST_M_ADD,    // seed: fold square into state, start u*mult
        ST_M_FIN,    // seed: finish mixer output, store word
        ST_W_READ,   // warmup: issue read
        ST_W_LOAD,   // warmup: prime the multiply
        ST_W_WB,     // warmup: write word and carry
        ST_MAC       // shared multiply-accumulate over partial products
    } state_t;

    // which product the accumulator is building
    typedef enum logic [1:0] {
        MAC_MWC,     // MWC_MULT * word + carry, full 128 bits
        MAC_SQR,     // s * s, low 64 bits
        MAC_MIX      // u * MIX_MULT, low 64 bits
    } mac_mode_t;

    // alignment of a partial product in the accumulator
    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_33,
        SH_64
    } shift_t;

    // word store: synchronous read, data registered in mem_rdata_reg
    logic [W-1:0] mem [lag64_mwc_pkg::LAG];
    logic [W-1:0] mem_rdata_reg;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [W-1:0]  mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;

    // valid bits stand in for the all-zero reset of the store
    logic [lag64_mwc_pkg::LAG-1:0] valid_reg, valid_next;
    logic                          rd_valid_reg, rd_valid_next;

    state_t    state_reg, state_next;
    state_t    ret_reg, ret_next;
    mac_mode_t mode_reg, mode_next;

    logic [W-1:0]   carry_reg, carry_next;
    logic [IW-1:0]  pos_reg, pos_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [IW-1:0]  pass_reg, pass_next;
    logic           stream_reg, stream_next;

    logic [W-1:0]   s0_reg, s0_next;
    logic [W-1:0]   s1_reg, s1_next;
    logic [W-1:0]   v_reg, v_next;

    // multiply-accumulate datapath
    logic [W-1:0]   opnd_reg, opnd_next;
    logic [2*W-1:0] acc_reg, acc_next;
    logic [W-1:0]   prod_reg, prod_next;
    shift_t         sh_reg, sh_next;
    logic           pend_reg, pend_next;
    logic [2:0]     term_reg, term_next;

    logic           m_tvalid_reg, m_tvalid_next;
    logic [W-1:0]   m_tdata_reg, m_tdata_next;

    // operand selection for the current partial product
    logic [H-1:0]   mul_a;
    logic [H-1:0]   mul_b;
    logic [W-1:0]   mul_prod;
    shift_t         sh_cur;
    logic [2:0]     nterms;
    logic [2*W-1:0] prod_aligned;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        sh_cur = SH_0;
        nterms = 3'd0;
        case (mode_reg)
            MAC_MWC: begin
                nterms = 3'd4;
                case (term_reg)
                    3'd0: begin
                        mul_a  = lag64_mwc_pkg::MWC_MULT[H-1:0];
                        mul_b  = opnd_reg[H-1:0];
                        sh_cur = SH_0;
                    end
                    3'd1: begin
                        mul_a  = lag64_mwc_pkg::MWC_MULT[H-1:0];
                        mul_b  = opnd_reg[W-1:H];
                        sh_cur = SH_32;
                    end
                    3'd2: begin
                        mul_a  = lag64_mwc_pkg::MWC_MULT[W-1:H];
                        mul_b  = opnd_reg[H-1:0];
                        sh_cur = SH_32;
                    end
                    default: begin
                        mul_a  = lag64_mwc_pkg::MWC_MULT[W-1:H];
                        mul_b  = opnd_reg[W-1:H];
                        sh_cur = SH_64;
                    end
                endcase
            end
            MAC_SQR: begin
                // low half of s*s: sl*sl + 2*sl*sh*2^32
                nterms = 3'd2;
                case (term_reg)
                    3'd0: begin
                        mul_a  = opnd_reg[H-1:0];
                        mul_b  = opnd_reg[H-1:0];
                        sh_cur = SH_0;
                    end
                    default: begin
                        mul_a  = opnd_reg[H-1:0];
                        mul_b  = opnd_reg[W-1:H];
                        sh_cur = SH_33;
                    end
                endcase
            end
            MAC_MIX: begin
                nterms = 3'd3;
                case (term_reg)
                    3'd0: begin
                        mul_a  = lag64_mwc_pkg::MIX_MULT[H-1:0];
                        mul_b  = opnd_reg[H-1:0];
                        sh_cur = SH_0;
                    end
                    3'd1: begin
                        mul_a  = lag64_mwc_pkg::MIX_MULT[W-1:H];
                        mul_b  = opnd_reg[H-1:0];
                        sh_cur = SH_32;
                    end
                    default: begin
                        mul_a  = lag64_mwc_pkg::MIX_MULT[H-1:0];
                        mul_b  = opnd_reg[W-1:H];
                        sh_cur = SH_32;
                    end
                endcase
            end
            default: begin
                nterms = 3'd0;
            end
        endcase
    end

    assign mul_prod = {{H{1'b0}}, mul_a} * {{H{1'b0}}, mul_b};

    // place the registered product at its weight
    always_comb begin
        case (sh_reg)
            SH_0:    prod_aligned = {{W{1'b0}}, prod_reg};
            SH_32:   prod_aligned = {{(W-32){1'b0}}, prod_reg, 32'd0};
            SH_33:   prod_aligned = {{(W-33){1'b0}}, prod_reg, 33'd0};
            SH_64:   prod_aligned = {prod_reg, {W{1'b0}}};
            default: prod_aligned = '0;
        endcase
    end

    // next-state logic
    always_comb begin
        logic [W-1:0] cur_s;
        logic [W-1:0] s_new;
        logic [W-1:0] u;
        logic [W-1:0] mix_out;

        state_next    = state_reg;
        ret_next      = ret_reg;
        mode_next     = mode_reg;
        carry_next    = carry_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        pass_next     = pass_reg;
        stream_next   = stream_reg;
        s0_next       = s0_reg;
        s1_next       = s1_reg;
        v_next        = v_reg;
        opnd_next     = opnd_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        sh_next       = sh_reg;
        pend_next     = pend_reg;
        term_next     = term_reg;
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        m_tdata_next  = m_tdata_reg;
        // output word leaves on its handshake
        m_tvalid_next = m_tvalid_reg & ~m_tready;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = pos_reg;

        cur_s   = stream_reg ? s1_reg : s0_reg;
        s_new   = cur_s + (acc_reg[W-1:0] | lag64_mwc_pkg::MIX_OR);
        u       = s_new ^ (s_new >> 32);
        mix_out = acc_reg[W-1:0]
                ^ ((acc_reg[W-1:0] << lag64_mwc_pkg::ROT_A)
                   | (acc_reg[W-1:0] >> (W - lag64_mwc_pkg::ROT_A)))
                ^ ((acc_reg[W-1:0] << lag64_mwc_pkg::ROT_B)
                   | (acc_reg[W-1:0] >> (W - lag64_mwc_pkg::ROT_B)));

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == lag64_mwc_pkg::KIND_SEED) begin
                        s0_next     = s_tdata[W-1:0];
                        s1_next     = s_tdata[2*W-1:W];
                        idx_next    = '0;
                        stream_next = 1'b0;
                        state_next  = ST_M_SQR;
                    end else begin
                        mem_re        = 1'b1;
                        mem_raddr     = pos_reg;
                        rd_valid_next = valid_reg[pos_reg];
                        state_next    = ST_P_READ;
                    end
                end
            end
            ST_P_READ: begin
                opnd_next  = rd_valid_reg ? mem_rdata_reg : '0;
                acc_next   = {{W{1'b0}}, carry_reg};
                mode_next  = MAC_MWC;
                term_next  = '0;
                pend_next  = 1'b0;
                ret_next   = ST_P_WB;
                state_next = ST_MAC;
            end
            ST_P_WB: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = acc_reg[W-1:0];
                valid_next[pos_reg] = 1'b1;
                carry_next = acc_reg[2*W-1:W];
                pos_next   = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg[W-1:0];
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_P_OUT;
                end
            end
            ST_P_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg[W-1:0];
                    state_next    = ST_IDLE;
                end
            end
            ST_M_SQR: begin
                opnd_next  = cur_s;
                acc_next   = '0;
                mode_next  = MAC_SQR;
                term_next  = '0;
                pend_next  = 1'b0;
                ret_next   = ST_M_ADD;
                state_next = ST_MAC;
            end
            ST_M_ADD: begin
                if (stream_reg) begin
                    s1_next = s_new;
                end else begin
                    s0_next = s_new;
                end
                opnd_next  = u;
                acc_next   = '0;
                mode_next  = MAC_MIX;
                term_next  = '0;
                pend_next  = 1'b0;
                ret_next   = ST_M_FIN;
                state_next = ST_MAC;
            end
            ST_M_FIN: begin
                if (!stream_reg) begin
                    v_next      = mix_out;
                    stream_next = 1'b1;
                    state_next  = ST_M_SQR;
                end else begin
                    mem_we      = 1'b1;
                    mem_waddr   = idx_reg;
                    mem_wdata   = v_reg + mix_out;
                    valid_next[idx_reg] = 1'b1;
                    stream_next = 1'b0;
                    if (idx_reg == LAST_IDX) begin
                        carry_next = lag64_mwc_pkg::CARRY_INIT;
                        idx_next   = '0;
                        pass_next  = '0;
                        state_next = ST_W_READ;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_M_SQR;
                    end
                end
            end
            ST_W_READ: begin
                mem_re        = 1'b1;
                mem_raddr     = idx_reg;
                rd_valid_next = valid_reg[idx_reg];
                state_next    = ST_W_LOAD;
            end
            ST_W_LOAD: begin
                opnd_next  = rd_valid_reg ? mem_rdata_reg : '0;
                acc_next   = {{W{1'b0}}, carry_reg};
                mode_next  = MAC_MWC;
                term_next  = '0;
                pend_next  = 1'b0;
                ret_next   = ST_W_WB;
                state_next = ST_MAC;
            end
            ST_W_WB: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = acc_reg[W-1:0];
                valid_next[idx_reg] = 1'b1;
                carry_next = acc_reg[2*W-1:W];
                if (idx_reg == LAST_IDX) begin
                    idx_next = '0;
                    if (pass_reg == LAST_IDX) begin
                        pos_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = ST_W_READ;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_W_READ;
                end
            end
            ST_MAC: begin
                // one partial product per cycle, added from prod_reg in the cycle after
                if (pend_reg) begin
                    acc_next = acc_reg + prod_aligned;
                end
                if (term_reg < nterms) begin
                    prod_next = mul_prod;
                    sh_next   = sh_cur;
                    pend_next = 1'b1;
                    term_next = term_reg + 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ret_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // word store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // sequencer state, datapath and output registers
    always_ff @(posedge aclk) begin
        ret_reg     <= ret_next;
        mode_reg    <= mode_next;
        idx_reg     <= idx_next;
        pass_reg    <= pass_next;
        stream_reg  <= stream_next;
        s0_reg      <= s0_next;
        s1_reg      <= s1_next;
        v_reg       <= v_next;
        opnd_reg    <= opnd_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        sh_reg      <= sh_next;
        pend_reg    <= pend_next;
        term_reg    <= term_next;
        rd_valid_reg <= rd_valid_next;
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            carry_reg    <= lag64_mwc_pkg::CARRY_INIT;
            pos_reg      <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            carry_reg    <= carry_next;
            pos_reg      <= pos_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
